[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the neuron bank RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of aclk, outside reset.
`define LIFN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define LIFN_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (expr)) else $error(msg);

`endif

[sv/lifn_pkg.sv]
// ----------------------------------------------------------------------------
// lifn_pkg
// Types and constants of the leaky integrate-and-fire neuron bank.
// ----------------------------------------------------------------------------
package lifn_pkg;

    localparam int CH_W     = 6;
    localparam int CH_CODES = 64;
    localparam int CUR_W    = 24;
    localparam int POT_W    = 32;
    localparam int GAIN_W   = 17;
    localparam int REFR_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 17'd65536;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_FACTOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFR_LENGTH    = 3'd4;

    // reset values
    localparam logic [GAIN_W-1:0]        RST_LEAK_FACTOR    = 17'd64050;
    localparam logic [GAIN_W-1:0]        RST_INPUT_GAIN     = 17'd1486;
    localparam logic signed [POT_W-1:0]  RST_FIRE_THRESHOLD = 32'sd1310720;
    localparam logic signed [POT_W-1:0]  RST_SPIKE_LEVEL    = 32'sd2293760;
    localparam logic [REFR_W-1:0]        RST_REFR_LENGTH    = 16'd220;

    typedef struct packed {
        logic [GAIN_W-1:0]       leak_factor;
        logic [GAIN_W-1:0]       input_gain;
        logic signed [POT_W-1:0] fire_threshold;
        logic signed [POT_W-1:0] spike_level;
        logic [REFR_W-1:0]       refractory_length;
    } cfg_t;

    // per-channel neuron state, one memory word
    typedef struct packed {
        logic signed [POT_W-1:0] membrane;
        logic [REFR_W-1:0]       refractory_left;
    } state_t;

    typedef struct packed {
        logic signed [POT_W-1:0] potential;
        logic                    spike;
    } res_t;

endpackage

[sv/lifn_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lifn_cfg_regs
// Configuration register file; clamps the two gain registers to 1.0.
// ----------------------------------------------------------------------------
module lifn_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lifn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lifn_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output lifn_pkg::cfg_t                    cfg
);

    lifn_pkg::cfg_t cfg_reg;
    logic [lifn_pkg::GAIN_W-1:0] gain_clamped;

    always_comb begin
        gain_clamped = cfg_wdata[lifn_pkg::GAIN_W-1:0];
        if (gain_clamped > lifn_pkg::GAIN_MAX) begin
            gain_clamped = lifn_pkg::GAIN_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leak_factor       <= lifn_pkg::RST_LEAK_FACTOR;
            cfg_reg.input_gain        <= lifn_pkg::RST_INPUT_GAIN;
            cfg_reg.fire_threshold    <= lifn_pkg::RST_FIRE_THRESHOLD;
            cfg_reg.spike_level       <= lifn_pkg::RST_SPIKE_LEVEL;
            cfg_reg.refractory_length <= lifn_pkg::RST_REFR_LENGTH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lifn_pkg::CFG_LEAK_FACTOR: begin
                    cfg_reg.leak_factor <= gain_clamped;
                end
                lifn_pkg::CFG_INPUT_GAIN: begin
                    cfg_reg.input_gain <= gain_clamped;
                end
                lifn_pkg::CFG_FIRE_THRESHOLD: begin
                    cfg_reg.fire_threshold <= $signed(cfg_wdata);
                end
                lifn_pkg::CFG_SPIKE_LEVEL: begin
                    cfg_reg.spike_level <= $signed(cfg_wdata);
                end
                lifn_pkg::CFG_REFR_LENGTH: begin
                    cfg_reg.refractory_length <= cfg_wdata[lifn_pkg::REFR_W-1:0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/lifn_state_mem.sv]
// ----------------------------------------------------------------------------
// lifn_state_mem
// Per-channel state memory: registered read with write-to-read bypass and a
// zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module lifn_state_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  lifn_pkg::state_t  wr_data,
    output lifn_pkg::state_t  rd_data,
    output logic              clear_busy
);

    lifn_pkg::state_t mem [DEPTH];
    lifn_pkg::state_t mem_rd_reg;
    lifn_pkg::state_t byp_data_reg;
    logic             byp_reg;
    logic             clr_busy_reg;
    logic [AW-1:0]    clr_idx_reg;

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_rd_reg   <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // take the word being written when it targets the address being read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_idx_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
        end
    end

    assign rd_data    = byp_reg ? byp_data_reg : mem_rd_reg;
    assign clear_busy = clr_busy_reg;

endmodule

[sv/lifn_datapath.sv]
// ----------------------------------------------------------------------------
// lifn_datapath
// One neuron update: leak, integrate, round, saturate, fire and refractory.
// ----------------------------------------------------------------------------
module lifn_datapath (
    input  lifn_pkg::state_t                    state_in,
    input  logic signed [lifn_pkg::CUR_W-1:0]   current,
    input  lifn_pkg::cfg_t                      cfg,
    output lifn_pkg::state_t                    state_out,
    output lifn_pkg::res_t                      res
);

    localparam int PM_W  = lifn_pkg::POT_W + lifn_pkg::GAIN_W + 1;
    localparam int PC_W  = lifn_pkg::CUR_W + lifn_pkg::GAIN_W + 1;
    localparam int ACC_W = PM_W + 1;
    localparam int Q_W   = ACC_W - 16;

    logic signed [PM_W-1:0]  prod_mem;
    logic signed [PC_W-1:0]  prod_cur;
    logic signed [ACC_W-1:0] acc;
    logic signed [Q_W-1:0]   q;
    logic signed [lifn_pkg::POT_W-1:0] pot_sat;
    logic                    ovf;

    always_comb begin
        prod_mem = state_in.membrane * $signed({1'b0, cfg.leak_factor});
        prod_cur = current * $signed({1'b0, cfg.input_gain});
        acc      = ACC_W'(prod_mem) + ACC_W'(prod_cur) + ACC_W'(32768);
        q        = acc[ACC_W-1:16];

        // saturate when the bits above the sign do not all match it
        ovf = (q[Q_W-1:lifn_pkg::POT_W-1] != '0) && (q[Q_W-1:lifn_pkg::POT_W-1] != '1);
        if (ovf) begin
            pot_sat = q[Q_W-1] ? {1'b1, {(lifn_pkg::POT_W-1){1'b0}}}
                               : {1'b0, {(lifn_pkg::POT_W-1){1'b1}}};
        end else begin
            pot_sat = q[lifn_pkg::POT_W-1:0];
        end

        if (state_in.refractory_left != '0) begin
            state_out.refractory_left = state_in.refractory_left - 16'd1;
            res.potential             = '0;
            res.spike                 = 1'b0;
        end else if (pot_sat > cfg.fire_threshold) begin
            state_out.refractory_left = (cfg.refractory_length != '0)
                                      ? cfg.refractory_length - 16'd1 : '0;
            res.potential             = cfg.spike_level;
            res.spike                 = 1'b1;
        end else begin
            state_out.refractory_left = '0;
            res.potential             = pot_sat;
            res.spike                 = 1'b0;
        end
        state_out.membrane = res.potential;
    end

endmodule

[sv/leaky_integrate_fire_neuron_bank.sv]
// ----------------------------------------------------------------------------
// leaky_integrate_fire_neuron_bank
// Bank of leaky integrate-and-fire neurons in Q15.16 fixed point, one state
// word per channel, updated by one request per cycle unless m_ready or the clear stalls.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_channel, s_current
//  m_        out        m_valid/m_ready    m_channel_out, m_potential, m_spike
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
//  Throughput is one request per cycle while m_ready does not stall; a result
//  passes the input register (with the state memory read), then the result
//  register. The single read-modify-write of the state memory sets the rate.
//  After reset a zero-fill sweep over all CHANNELS entries clears the memory;
//  s_ready stays low during it, configuration writes are taken as usual.
//  A stalled m_ready holds the result register and then the input stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module leaky_integrate_fire_neuron_bank #(
    parameter int CHANNELS = 64
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // requests
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [lifn_pkg::CH_W-1:0]               s_channel,
    input  logic signed [lifn_pkg::CUR_W-1:0]       s_current,
    // results
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [lifn_pkg::CH_W-1:0]               m_channel_out,
    output logic signed [lifn_pkg::POT_W-1:0]       m_potential,
    output logic                                    m_spike,
    // configuration
    input  logic                                    cfg_wr_en,
    input  logic [lifn_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lifn_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    lifn_pkg::cfg_t   cfg;
    lifn_pkg::state_t state_rd;
    lifn_pkg::state_t state_wr;
    lifn_pkg::res_t   res;

    logic [IDX_W-1:0] idx_lut [lifn_pkg::CH_CODES];
    logic [IDX_W-1:0] s_idx;
    logic             clear_busy;
    logic             s_accept;
    logic             s1_adv;

    // input stage
    logic                                s1_valid_reg;
    logic [lifn_pkg::CH_W-1:0]           s1_channel_reg;
    logic signed [lifn_pkg::CUR_W-1:0]   s1_current_reg;
    logic [IDX_W-1:0]                    s1_idx_reg;

    // result stage
    logic                                m_valid_reg;
    logic [lifn_pkg::CH_W-1:0]           m_channel_reg;
    logic signed [lifn_pkg::POT_W-1:0]   m_potential_reg;
    logic                                m_spike_reg;

    // Map every channel code to its state entry (channel modulo CHANNELS).
    for (genvar gi = 0; gi < lifn_pkg::CH_CODES; gi++) begin : g_idx
        assign idx_lut[gi] = IDX_W'(gi % CHANNELS);
    end
    assign s_idx = idx_lut[s_channel];

    lifn_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Advance the input stage when the result register is free or drains.
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clear_busy && (!s1_valid_reg || s1_adv);
    assign s_accept = s_valid && s_ready;

    // Read the channel state on accept; write back the update as the item
    // leaves the input stage. Back-to-back requests to one channel take the
    // written word through the memory's bypass.
    lifn_state_mem #(
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (s_accept),
        .rd_addr    (s_idx),
        .wr_en      (s1_adv),
        .wr_addr    (s1_idx_reg),
        .wr_data    (state_wr),
        .rd_data    (state_rd),
        .clear_busy (clear_busy)
    );

    lifn_datapath u_dp (
        .state_in  (state_rd),
        .current   (s1_current_reg),
        .cfg       (cfg),
        .state_out (state_wr),
        .res       (res)
    );

    // input stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_channel_reg <= s_channel;
            s1_current_reg <= s_current;
            s1_idx_reg     <= s_idx;
        end
    end

    // result register control: load on advance, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_channel_reg   <= s1_channel_reg;
            m_potential_reg <= res.potential;
            m_spike_reg     <= res.spike;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_reg;
    assign m_potential   = m_potential_reg;
    assign m_spike       = m_spike_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `LIFN_ASSERT(a_no_accept_in_clear, !(s_ready && clear_busy), "request taken during clear")
    `LIFN_ASSERT(a_spike_level, !(m_valid && m_spike) || (m_potential == cfg.spike_level),
        "spike without spike level")
    `LIFN_ASSERT_NEXT(a_adv_loads_result, s1_adv, m_valid, "advanced item lost")
    `LIFN_ASSERT_NEXT(a_accept_fills_stage, s_accept, s1_valid_reg, "accepted request lost")

endmodule
